// ===== rtl/qsrsc_pkg.sv =====
// shared types and codes for the stream receive state checker
// no dependencies; imported by qsrsc_step and the top level
package qsrsc_pkg;

  typedef enum logic [2:0] {
    ACT_DATA  = 3'd0,
    ACT_RESET = 3'd1,
    ACT_RAISE = 3'd2,
    ACT_TAKE  = 3'd3,
    ACT_ACK   = 3'd4,
    ACT_LOST  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIRECTION = 2'd1,
    ST_CLOSED    = 2'd2,
    ST_CONFLICT  = 2'd3
  } status_e;

  // max_stream_data frame lifecycle
  typedef enum logic [3:0] {
    FS_NONE    = 4'b0001,
    FS_PENDING = 4'b0010,
    FS_SENT    = 4'b0100,
    FS_ACKED   = 4'b1000
  } frame_state_e;

  typedef enum logic [1:0] {
    REG_STREAM_NUMBER   = 2'd0,
    REG_LOCAL_IS_CLIENT = 2'd1,
    REG_INITIAL_LIMIT   = 2'd2
  } cfg_reg_e;

  localparam int unsigned SidW = 62;
  localparam int unsigned OffW = 64;
  localparam int unsigned LenW = 16;

  localparam logic [SidW-1:0] SidInitiatorBit = SidW'(64'h01);
  localparam logic [SidW-1:0] SidUniBit       = SidW'(64'h02);

  typedef struct packed {
    logic [SidW-1:0] stream_number;
    logic            is_client;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      action;
    logic [OffW-1:0] offset;
    logic [LenW-1:0] length;
    logic            fin;
    logic [OffW-1:0] value;
    logic [SidW-1:0] frame_stream;
  } item_t;

  typedef struct packed {
    logic [OffW-1:0] highest;
    logic [OffW-1:0] total_size;
    logic            final_known;
    logic            send_done;
    logic            reset_flag;
    logic [OffW-1:0] limit;
    logic [OffW-1:0] frame_value;
    logic            frame_present;
    frame_state_e    frame_state;
  } rx_state_t;

  typedef struct packed {
    status_e         status;
    logic            frame_valid;
    logic [OffW-1:0] frame_maximum;
  } step_res_t;

endpackage

// ===== rtl/qsrsc_step.sv =====
// next-state and result logic for one beat of the stream receive checker
// depends on qsrsc_pkg
module qsrsc_step (
  input  qsrsc_pkg::cfg_t      cfg_i,
  input  qsrsc_pkg::rx_state_t state_i,
  input  qsrsc_pkg::item_t     item_i,
  output qsrsc_pkg::rx_state_t state_o,
  output qsrsc_pkg::step_res_t res_o
);
  import qsrsc_pkg::*;

  logic            may_receive;
  logic            client_opened;
  logic            local_opened;
  logic [OffW:0]   end_sum;
  logic [OffW-1:0] span_end;
  logic [OffW-1:0] highest_new;
  logic            fin_conflict;
  logic            reset_conflict;
  logic            frame_match;

  assign client_opened = (cfg_i.stream_number & SidInitiatorBit) == '0;
  assign local_opened  = (cfg_i.is_client == client_opened);
  assign may_receive   = ((cfg_i.stream_number & SidUniBit) == '0) || !local_opened;

  // range end saturates at all-ones
  assign end_sum  = {1'b0, item_i.offset} + {{(OffW+1-LenW){1'b0}}, item_i.length};
  assign span_end = end_sum[OffW] ? '1 : end_sum[OffW-1:0];

  assign highest_new = (span_end > state_i.highest) ? span_end : state_i.highest;

  // highest is raised before the fin check
  assign fin_conflict = (state_i.final_known && (state_i.total_size != span_end)) ||
                        (highest_new > span_end);
  assign reset_conflict = (state_i.final_known && (state_i.total_size != item_i.value)) ||
                          (state_i.highest > item_i.value);

  assign frame_match = state_i.frame_present &&
                       (item_i.frame_stream == cfg_i.stream_number) &&
                       (item_i.value == state_i.frame_value);

  always_comb begin
    state_o           = state_i;
    res_o.status      = ST_OK;
    res_o.frame_valid = 1'b0;
    res_o.frame_maximum = '0;
    case (action_e'(item_i.action))
      ACT_DATA: begin
        if (!may_receive) begin
          res_o.status = ST_DIRECTION;
        end else if (span_end > state_i.limit) begin
          res_o.status = ST_CONFLICT;
        end else if (state_i.final_known && (span_end > state_i.total_size)) begin
          res_o.status = ST_CONFLICT;
        end else begin
          state_o.highest = highest_new;
          if (item_i.fin) begin
            if (fin_conflict) begin
              res_o.status = ST_CONFLICT;
            end else begin
              state_o.total_size  = span_end;
              state_o.final_known = 1'b1;
              state_o.send_done   = 1'b1;
            end
          end
        end
      end
      ACT_RESET: begin
        if (!may_receive) begin
          res_o.status = ST_DIRECTION;
        end else if (reset_conflict) begin
          res_o.status = ST_CONFLICT;
        end else begin
          state_o.total_size  = item_i.value;
          state_o.final_known = 1'b1;
          state_o.send_done   = 1'b1;
          state_o.reset_flag  = 1'b1;
        end
      end
      ACT_RAISE: begin
        if (item_i.value > state_i.limit) begin
          state_o.limit         = item_i.value;
          state_o.frame_value   = item_i.value;
          state_o.frame_present = 1'b1;
          state_o.frame_state   = FS_PENDING;
        end
      end
      ACT_TAKE: begin
        if ((state_i.frame_state == FS_PENDING) && state_i.frame_present) begin
          state_o.frame_state = FS_SENT;
          res_o.frame_valid   = 1'b1;
          res_o.frame_maximum = state_i.frame_value;
        end
      end
      ACT_ACK: begin
        if (frame_match) begin
          state_o.frame_state = FS_ACKED;
        end
      end
      ACT_LOST: begin
        if ((state_i.frame_state != FS_ACKED) && frame_match) begin
          state_o.frame_state = FS_PENDING;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/quic_stream_receive_state_checker_core.sv =====
// Receive half of one stream: flow-control limit, final size and limit frame lifecycle.
// One beat is accepted per cycle when the result side keeps up; an accepted beat is held
// in the input register, and its result is loaded into the result register once that
// register is free or its result is being taken. Between those registers sits the
// single-pass update of the stream state: a 64-bit saturating add of offset and length and
// its compares against the limit, the final size and the highest offset. There is no
// clearing pass after reset. Configuration writes (stream id, role, initial limit) must be
// made only while no beat is in flight; writing the initial limit also reloads the
// advertised limit.
// depends on qsrsc_pkg and qsrsc_step
module quic_stream_receive_state_checker_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [qsrsc_pkg::OffW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  action_i,
  input  logic [qsrsc_pkg::OffW-1:0]  offset_i,
  input  logic [qsrsc_pkg::LenW-1:0]  length_i,
  input  logic                        fin_i,
  input  logic [qsrsc_pkg::OffW-1:0]  value_i,
  input  logic [qsrsc_pkg::SidW-1:0]  frame_stream_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output qsrsc_pkg::status_e          status_o,
  output logic                        frame_valid_o,
  output logic [qsrsc_pkg::OffW-1:0]  frame_maximum_o,
  output logic                        peer_closed_o,
  output logic                        reset_seen_o,
  output logic [qsrsc_pkg::OffW-1:0]  highest_offset_o
);
  import qsrsc_pkg::*;

  cfg_t      cfg_q;
  rx_state_t state_q;
  rx_state_t state_next;
  step_res_t res_next;
  item_t     item_q;
  logic      in_valid_q;
  logic      out_valid_q;
  logic      advance;
  logic      in_take;

  status_e         status_q;
  logic            frame_valid_q;
  logic [OffW-1:0] frame_maximum_q;
  logic            peer_closed_q;
  logic            reset_seen_q;
  logic [OffW-1:0] highest_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  qsrsc_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_next),
    .res_o   (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stream_number <= '0;
      cfg_q.is_client     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STREAM_NUMBER:   cfg_q.stream_number <= cfg_wdata_i[SidW-1:0];
        REG_LOCAL_IS_CLIENT: cfg_q.is_client     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.highest       <= '0;
      state_q.total_size    <= '0;
      state_q.final_known   <= 1'b0;
      state_q.send_done     <= 1'b0;
      state_q.reset_flag    <= 1'b0;
      state_q.limit         <= '1;
      state_q.frame_value   <= '0;
      state_q.frame_present <= 1'b0;
      state_q.frame_state   <= FS_NONE;
    end else if (advance) begin
      state_q <= state_next;
    end else if (cfg_we_i && (cfg_reg_e'(cfg_index_i) == REG_INITIAL_LIMIT)) begin
      state_q.limit <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action       <= action_i;
      item_q.offset       <= offset_i;
      item_q.length       <= length_i;
      item_q.fin          <= fin_i;
      item_q.value        <= value_i;
      item_q.frame_stream <= frame_stream_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q        <= res_next.status;
      frame_valid_q   <= res_next.frame_valid;
      frame_maximum_q <= res_next.frame_maximum;
      peer_closed_q   <= state_next.send_done;
      reset_seen_q    <= state_next.reset_flag;
      highest_q       <= state_next.highest;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign frame_valid_o    = frame_valid_q;
  assign frame_maximum_o  = frame_maximum_q;
  assign peer_closed_o    = peer_closed_q;
  assign reset_seen_o     = reset_seen_q;
  assign highest_offset_o = highest_q;

`ifndef SYNTHESIS
  a_highest_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> state_q.highest >= $past(state_q.highest))
    else $error("highest offset went down");

  a_frame_present : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.frame_state != FS_NONE) |-> state_q.frame_present)
    else $error("frame lifecycle active without a queued frame");

  a_reset_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reset_seen_o) |-> peer_closed_o)
    else $error("peer reset reported without peer close");

  a_frame_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_valid_o) |-> (status_o == ST_OK))
    else $error("taken frame reported with error status");

  a_take_sent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_next.frame_valid) |=> (state_q.frame_state == FS_SENT))
    else $error("taken frame not marked sent");
`endif

endmodule

// ===== dv/quic_stream_receive_state_checker_core_test.sv =====
// self-checking testbench for quic_stream_receive_state_checker_core
// uses qsrsc_pkg for the port types, action/status/register codes and item_t
module quic_stream_receive_state_checker_core_test;
  import qsrsc_pkg::*;

  localparam logic [2:0]  ACT_UNUSED_6   = 3'd6;
  localparam logic [2:0]  ACT_UNUSED_7   = 3'd7;
  localparam logic [63:0] DIR_LIMIT      = 64'h0001_0000_0000_0000;
  localparam logic [63:0] DIR_RAISE      = 64'h0001_0000_0000_1000;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASE_COUNT    = 6;
  localparam int          PHASE_BEATS    = 100;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    status_e     status;
    logic        frame_valid;
    logic [63:0] frame_maximum;
    logic        peer_closed;
    logic        reset_seen;
    logic [63:0] highest;
  } rx_result_t;

  typedef struct {
    item_t   beat;
    logic    typed;
    status_e typed_status;
  } stim_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [1:0]      cfg_index_i;
  logic [63:0]     cfg_wdata_i;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [2:0]      action_i;
  logic [63:0]     offset_i;
  logic [15:0]     length_i;
  logic            fin_i;
  logic [63:0]     value_i;
  logic [61:0]     frame_stream_i;
  logic            out_valid_o;
  logic            out_stall_i;
  status_e         status_o;
  logic            frame_valid_o;
  logic [63:0]     frame_maximum_o;
  logic            peer_closed_o;
  logic            reset_seen_o;
  logic [63:0]     highest_offset_o;

  // mirror of the configuration and the stream state
  logic [61:0]     cfg_sid          = '0;
  logic            cfg_client       = 1'b1;
  logic [63:0]     rx_highest       = '0;
  logic [63:0]     rx_final_size    = '0;
  logic            rx_final_known   = 1'b0;
  logic            rx_send_done     = 1'b0;
  logic            rx_reset_seen    = 1'b0;
  logic [63:0]     rx_limit         = '1;
  logic [63:0]     rx_frame_value   = '0;
  logic            rx_frame_present = 1'b0;
  frame_state_e    rx_frame_state   = FS_NONE;

  rx_result_t      predicted_results[$];
  stim_row_t       directed_rows[$];
  idle_mode_e      idle_mode  = IDLE_NONE;
  int              mismatches = 0;
  int              quiet_cycles = 0;

  quic_stream_receive_state_checker_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .offset_i         (offset_i),
    .length_i         (length_i),
    .fin_i            (fin_i),
    .value_i          (value_i),
    .frame_stream_i   (frame_stream_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .frame_valid_o    (frame_valid_o),
    .frame_maximum_o  (frame_maximum_o),
    .peer_closed_o    (peer_closed_o),
    .reset_seen_o     (reset_seen_o),
    .highest_offset_o (highest_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic receive_allowed();
    logic client_opened;
    logic unidirectional;
    logic local_opened;
    client_opened  = (cfg_sid & SidInitiatorBit) == '0;
    unidirectional = (cfg_sid & SidUniBit) != '0;
    local_opened   = cfg_client == client_opened;
    return !unidirectional || !local_opened;
  endfunction

  function automatic status_e settle_final_size(logic [63:0] size);
    if (rx_final_known && rx_final_size != size) return ST_CONFLICT;
    if (rx_highest > size) return ST_CONFLICT;
    rx_final_size  = size;
    rx_final_known = 1'b1;
    return ST_OK;
  endfunction

  function automatic logic limit_frame_hit(item_t b);
    return rx_frame_present && b.frame_stream == cfg_sid && b.value == rx_frame_value;
  endfunction

  // advances the stream state by one beat and returns the result it causes
  function automatic rx_result_t apply_beat(item_t b);
    rx_result_t  r;
    logic [64:0] sum;
    logic [63:0] span_end;
    r = '0;
    r.status = ST_OK;
    case (b.action)
      ACT_DATA: begin
        if (!receive_allowed()) begin
          r.status = ST_DIRECTION;
        end else begin
          sum = {1'b0, b.offset} + 65'(b.length);
          span_end = sum[64] ? '1 : sum[63:0];
          if (span_end > rx_limit) begin
            r.status = ST_CONFLICT;
          end else if (rx_final_known && span_end > rx_final_size) begin
            r.status = ST_CONFLICT;
          end else begin
            // highest end moves even when the fin check below fails
            if (span_end > rx_highest) rx_highest = span_end;
            if (b.fin) begin
              r.status = settle_final_size(span_end);
              if (r.status == ST_OK) rx_send_done = 1'b1;
            end
          end
        end
      end
      ACT_RESET: begin
        if (!receive_allowed()) begin
          r.status = ST_DIRECTION;
        end else begin
          r.status = settle_final_size(b.value);
          if (r.status == ST_OK) begin
            rx_send_done  = 1'b1;
            rx_reset_seen = 1'b1;
          end
        end
      end
      ACT_RAISE: begin
        if (b.value > rx_limit) begin
          rx_limit         = b.value;
          rx_frame_value   = b.value;
          rx_frame_present = 1'b1;
          rx_frame_state   = FS_PENDING;
        end
      end
      ACT_TAKE: begin
        if (rx_frame_state == FS_PENDING && rx_frame_present) begin
          rx_frame_state  = FS_SENT;
          r.frame_valid   = 1'b1;
          r.frame_maximum = rx_frame_value;
        end
      end
      ACT_ACK: begin
        if (limit_frame_hit(b)) rx_frame_state = FS_ACKED;
      end
      ACT_LOST: begin
        if (rx_frame_state != FS_ACKED && limit_frame_hit(b)) rx_frame_state = FS_PENDING;
      end
      default: ;
    endcase
    r.peer_closed = rx_send_done;
    r.reset_seen  = rx_reset_seen;
    r.highest     = rx_highest;
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic [2:0] act, logic [63:0] off, logic [15:0] len,
                                         logic fin, logic [63:0] val, logic [61:0] fs,
                                         logic typed, status_e st);
    stim_row_t row;
    row.beat.action       = act;
    row.beat.offset       = off;
    row.beat.length       = len;
    row.beat.fin          = fin;
    row.beat.value        = val;
    row.beat.frame_stream = fs;
    row.typed             = typed;
    row.typed_status      = st;
    return row;
  endfunction

  function automatic void add_row(stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // random beat, mostly shaped from the current state so that it gets past the checks
  task automatic shape_beat(output item_t b);
    int unsigned pick;
    logic [63:0] bound;
    logic [63:0] upper;
    logic [15:0] len;
    b.action       = 3'($urandom);
    b.offset       = rand64();
    b.length       = 16'($urandom);
    b.fin          = 1'($urandom);
    b.value        = rand64();
    b.frame_stream = 62'(rand64());
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      b.action = ACT_DATA;
      bound = rx_limit;
      if (rx_final_known && rx_final_size < bound) bound = rx_final_size;
      len = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
      if (bound < 64'(len)) len = bound[15:0];
      upper = bound - 64'(len);
      case ($urandom_range(0, 3))
        0: b.offset = upper;
        1: b.offset = (rx_highest < upper) ? rx_highest : upper;
        2: b.offset = (upper == '1) ? rand64() : rand64() % (upper + 64'd1);
        default: b.offset = (upper < 64'd4000) ? upper : 64'($urandom_range(0, 4000));
      endcase
      b.length = len;
      b.fin = ($urandom_range(0, 5) == 0);
      // a fin that lands exactly on the known final size
      if (b.fin && rx_final_known && rx_final_size >= 64'(len)) begin
        b.offset = rx_final_size - 64'(len);
      end
    end else if (pick < 42) begin
      b.action = ACT_DATA;
      if ($urandom_range(0, 2) == 0) b.offset = ~64'($urandom_range(0, 70000));
    end else if (pick < 48) begin
      b.action = ACT_RESET;
      if ($urandom_range(0, 1) != 0) begin
        b.value = rx_final_known ? rx_final_size : rx_highest + 64'($urandom_range(0, 5000));
      end
    end else if (pick < 60) begin
      b.action = ACT_RAISE;
      case ($urandom_range(0, 3))
        0, 1: b.value = rx_limit + 64'($urandom_range(1, 100000));
        2: b.value = rx_limit;
        default: ;
      endcase
    end else if (pick < 74) begin
      b.action = ACT_TAKE;
    end else if (pick < 94) begin
      b.action = (pick < 84) ? ACT_ACK : ACT_LOST;
      if ($urandom_range(0, 9) < 7) begin
        b.frame_stream = cfg_sid;
        b.value        = rx_frame_value;
      end else if ($urandom_range(0, 1) != 0) begin
        b.frame_stream = cfg_sid;
      end else begin
        b.value = rx_frame_value;
      end
    end else begin
      b.action = ($urandom_range(0, 1) != 0) ? ACT_UNUSED_6 : ACT_UNUSED_7;
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_STREAM_NUMBER:   cfg_sid    = data[61:0];
      REG_LOCAL_IS_CLIENT: cfg_client = data[0];
      REG_INITIAL_LIMIT:   rx_limit   = data;
      default: ;
    endcase
  endtask

  task automatic sender_gap();
    while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 74) ||
           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 9)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_beat(item_t b, logic typed, status_e typed_status);
    rx_result_t r;
    in_valid_i     <= 1'b1;
    action_i       <= b.action;
    offset_i       <= b.offset;
    length_i       <= b.length;
    fin_i          <= b.fin;
    value_i        <= b.value;
    frame_stream_i <= b.frame_stream;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_beat(b);
    if (typed) begin
      r = '0;
      r.status = typed_status;
    end
    predicted_results.insert(predicted_results.size(), r);
  endtask

  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: out_stall_i <= ($urandom_range(0, 99) < 74);
      IDLE_BOTH: out_stall_i <= ($urandom_range(0, 99) < 9);
      default:   out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin : check_results
    rx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: st=%0d fv=%0d fmax=%h pc=%0d rs=%0d hi=%h",
                   status_o, frame_valid_o, frame_maximum_o, peer_closed_o, reset_seen_o,
                   highest_offset_o);
        end
      end else begin
        want = predicted_results.pop_front();
        if (want.status !== status_o || want.frame_valid !== frame_valid_o ||
            want.frame_maximum !== frame_maximum_o || want.peer_closed !== peer_closed_o ||
            want.reset_seen !== reset_seen_o || want.highest !== highest_offset_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp st=%0d fv=%0d fmax=%h pc=%0d rs=%0d hi=%h", want.status,
                     want.frame_valid, want.frame_maximum, want.peer_closed, want.reset_seen,
                     want.highest);
            $display("         got st=%0d fv=%0d fmax=%h pc=%0d rs=%0d hi=%h", status_o,
                     frame_valid_o, frame_maximum_o, peer_closed_o, reset_seen_o,
                     highest_offset_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    item_t       b;
    logic [61:0] sid;
    logic        client;
    logic [63:0] lim;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= REG_STREAM_NUMBER;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_DATA;
    offset_i       <= '0;
    length_i       <= '0;
    fin_i          <= 1'b0;
    value_i        <= '0;
    frame_stream_i <= '0;

    add_row(stim_row(ACT_DATA, 0, 0, 0, 0, 0, 1, ST_OK));
    // range end saturates and lands above the limit
    add_row(stim_row(ACT_DATA, '1, 16'hffff, 1, 0, 0, 1, ST_CONFLICT));
    add_row(stim_row(ACT_RAISE, 0, 0, 0, 64'd5, 0, 1, ST_OK));
    add_row(stim_row(ACT_TAKE, 0, 0, 0, 0, 0, 1, ST_OK));
    // frame value and stream id match but no frame exists yet
    add_row(stim_row(ACT_ACK, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(stim_row(ACT_LOST, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(stim_row(ACT_UNUSED_6, '1, 16'hffff, 1, '1, '1, 1, ST_OK));
    add_row(stim_row(ACT_UNUSED_7, '1, 16'hffff, 1, '1, '1, 1, ST_OK));
    add_row(stim_row(ACT_DATA, 1000, 16'hffff, 0, 0, 0, 0, ST_OK));
    add_row(stim_row(ACT_DATA, DIR_LIMIT - 100, 101, 0, 0, 0, 0, ST_OK));
    add_row(stim_row(ACT_DATA, DIR_LIMIT - 100, 100, 0, 0, 0, 0, ST_OK));
    // fin below the highest end
    add_row(stim_row(ACT_DATA, 0, 16, 1, 0, 0, 0, ST_OK));
    add_row(stim_row(ACT_RAISE, 0, 0, 0, DIR_RAISE, 0, 0, ST_OK));
    add_row(stim_row(ACT_TAKE, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(stim_row(ACT_LOST, 0, 0, 0, DIR_RAISE + 1, 0, 0, ST_OK));
    add_row(stim_row(ACT_LOST, 0, 0, 0, DIR_RAISE, 0, 0, ST_OK));
    add_row(stim_row(ACT_TAKE, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(stim_row(ACT_ACK, 0, 0, 0, DIR_RAISE, 1, 0, ST_OK));
    add_row(stim_row(ACT_ACK, 0, 0, 0, DIR_RAISE, 0, 0, ST_OK));
    // lost after ack leaves the frame acknowledged
    add_row(stim_row(ACT_LOST, 0, 0, 0, DIR_RAISE, 0, 0, ST_OK));
    add_row(stim_row(ACT_TAKE, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(stim_row(ACT_RESET, 0, 0, 0, 64'd100, 0, 0, ST_OK));
    add_row(stim_row(ACT_RESET, 0, 0, 0, '1, 0, 0, ST_OK));
    add_row(stim_row(ACT_RESET, 0, 0, 0, 64'd5, 0, 0, ST_OK));
    // data after the peer reset is still taken
    add_row(stim_row(ACT_DATA, 70000, 500, 0, 0, 0, 0, ST_OK));
    add_row(stim_row(ACT_DATA, 0, 0, 1, 0, 0, 0, ST_OK));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_INITIAL_LIMIT, DIR_LIMIT);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].typed_status);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      case (p)
        0: begin sid = {60'(rand64()), 2'b00}; client = 1'b1; lim = 64'h1_0000_0000; end
        1: begin sid = {60'(rand64()), 2'b10}; client = 1'b1; lim = rand64(); end
        2: begin sid = {60'(rand64()), 2'b11}; client = 1'b1; lim = '0; end
        3: begin sid = '1; client = 1'b0; lim = 64'hffff; end
        4: begin sid = '0; client = 1'b0; lim = rand64() >> $urandom_range(0, 40); end
        default: begin sid = {60'(rand64()), 2'b10}; client = 1'b0; lim = '1; end
      endcase
      write_reg(REG_STREAM_NUMBER, {2'($urandom), sid});
      write_reg(REG_LOCAL_IS_CLIENT, {63'(rand64()), client});
      write_reg(REG_INITIAL_LIMIT, lim);
      cfg_we_i <= 1'b0;
      case (p)
        0: idle_mode = IDLE_NONE;
        1, 4: idle_mode = IDLE_SEND;
        2, 5: idle_mode = IDLE_RECV;
        default: idle_mode = IDLE_BOTH;
      endcase
      @(posedge clk_i);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i == PHASE_BEATS / 2) wait_drained();
        sender_gap();
        shape_beat(b);
        send_beat(b, 1'b0, ST_OK);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== quic_stream_receive_state_checker_core.f =====
rtl/qsrsc_pkg.sv
rtl/qsrsc_step.sv
rtl/quic_stream_receive_state_checker_core.sv
dv/quic_stream_receive_state_checker_core_test.sv
